>>> src/cdtf_pkg.sv
// Shared constants, types and CRC/digit helper functions for the CRC-16 trailer framer.
`default_nettype none
package cdtf_pkg;

  localparam logic [7:0] SEP_LEAD  = 8'hA1;
  localparam logic [7:0] SEP_MID   = 8'hF5;
  localparam logic [7:0] SEP_CLOSE = 8'hF6;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // floor(x / 99) == (x * MOD_RECIP) >> MOD_SHIFT for every 16-bit x
  localparam logic [15:0] MOD_RECIP = 16'd42367;
  localparam int unsigned MOD_SHIFT = 22;
  localparam logic [16:0] CHECK_MOD = 17'd99;

  // carry-less multiples of 0x1021 by a nibble
  localparam logic [15:0] NIBBLE_TBL [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
    16'h8108, 16'h9129, 16'hA14A, 16'hB16B, 16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
  };

  // strobes from the sequencer to the CRC unit
  typedef struct packed {
    logic load_data;  // fold the accepted message word
    logic fold_lead;  // fold separator A1
    logic fold_mid;   // fold separator F5
    logic mul;        // start mod-99 reduction
    logic rem;        // finish mod-99 reduction
    logic clear;      // end of frame
  } crc_ctrl_t;

  function automatic logic [15:0] fold_nibble(input logic [15:0] c, input logic [3:0] nib);
    logic [3:0] idx;
    idx = c[15:12] ^ nib;
    return {c[11:0], 4'h0} ^ NIBBLE_TBL[idx];
  endfunction

  function automatic logic [15:0] fold_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] t;
    t = fold_nibble(c, b[7:4]);
    return fold_nibble(t, b[3:0]);
  endfunction

  // tens digit of a value below 99: (r * 205) >> 11
  function automatic logic [3:0] tens_of(input logic [6:0] r);
    logic [14:0] p;
    p = {8'd0, r} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(input logic [6:0] r);
    logic [6:0] t10;
    t10 = {3'd0, tens_of(r)} * 7'd10;
    return 4'(r - t10);
  endfunction

endpackage
`default_nettype wire

>>> src/cdtf_crc.sv
// Running CRC-16 register and two-step mod-99 reduction of the final CRC.
`default_nettype none
module cdtf_crc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cdtf_pkg::crc_ctrl_t ctrl,
  input  wire logic [7:0]         data_byte,
  output logic [6:0]              rem_r
);

  logic [15:0] crc_r, crc_nxt;
  logic [31:0] prod_r;
  logic [9:0]  quot;
  logic [16:0] qx99;
  logic [16:0] diff;

  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.clear) begin
      crc_nxt = 16'h0000;
    end else if (ctrl.load_data) begin
      crc_nxt = cdtf_pkg::fold_byte(crc_r, data_byte);
    end else if (ctrl.fold_lead) begin
      crc_nxt = cdtf_pkg::fold_byte(crc_r, cdtf_pkg::SEP_LEAD);
    end else if (ctrl.fold_mid) begin
      crc_nxt = cdtf_pkg::fold_byte(crc_r, cdtf_pkg::SEP_MID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 16'h0000;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  // quotient from the registered reciprocal product, remainder one word later
  assign quot = prod_r[31:cdtf_pkg::MOD_SHIFT];
  assign qx99 = {7'd0, quot} * cdtf_pkg::CHECK_MOD;
  assign diff = {1'b0, crc_r} - qx99;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= {16'd0, crc_r} * {16'd0, cdtf_pkg::MOD_RECIP};
    end
    if (ctrl.rem) begin
      rem_r <= diff[6:0];
    end
  end

endmodule
`default_nettype wire

>>> src/cdtf_seq.sv
// Handshake, trailer sequencer and output register of the framer.
`default_nettype none
module cdtf_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_last_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_out_byte,
  output logic                     out_frame_end,
  input  wire logic [6:0]          rem,
  output cdtf_pkg::crc_ctrl_t      ctrl
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_LEAD1 = 4'd1;
  localparam logic [3:0] PH_MID   = 4'd2;
  localparam logic [3:0] PH_LEAD2 = 4'd3;
  localparam logic [3:0] PH_CLS1  = 4'd4;
  localparam logic [3:0] PH_TENS  = 4'd5;
  localparam logic [3:0] PH_UNITS = 4'd6;
  localparam logic [3:0] PH_LEAD3 = 4'd7;
  localparam logic [3:0] PH_CLS2  = 4'd8;

  logic [3:0] phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       end_r, end_nxt;
  logic       load;
  logic       in_acc;

  assign load     = !valid_r || out_ready;
  assign in_ready = (phase_r == PH_IDLE) && load;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    ctrl      = '0;
    if (phase_r == PH_IDLE) begin
      if (in_acc) begin
        valid_nxt      = 1'b1;
        byte_nxt       = in_data_byte;
        end_nxt        = 1'b0;
        ctrl.load_data = 1'b1;
        phase_nxt      = in_last_byte ? PH_LEAD1 : PH_IDLE;
      end else if (load) begin
        valid_nxt = 1'b0;
      end
    end else if (load) begin
      valid_nxt = 1'b1;
      end_nxt   = 1'b0;
      phase_nxt = phase_r + 4'd1;
      case (phase_r)
        PH_LEAD1: begin
          byte_nxt       = cdtf_pkg::SEP_LEAD;
          ctrl.fold_lead = 1'b1;
        end
        PH_MID: begin
          byte_nxt      = cdtf_pkg::SEP_MID;
          ctrl.fold_mid = 1'b1;
        end
        PH_LEAD2: begin
          byte_nxt = cdtf_pkg::SEP_LEAD;
          ctrl.mul = 1'b1;
        end
        PH_CLS1: begin
          byte_nxt = cdtf_pkg::SEP_CLOSE;
          ctrl.rem = 1'b1;
        end
        PH_TENS: begin
          byte_nxt = cdtf_pkg::ASCII_ZERO + {4'd0, cdtf_pkg::tens_of(rem)};
        end
        PH_UNITS: begin
          byte_nxt = cdtf_pkg::ASCII_ZERO + {4'd0, cdtf_pkg::units_of(rem)};
        end
        PH_LEAD3: begin
          byte_nxt = cdtf_pkg::SEP_LEAD;
        end
        PH_CLS2: begin
          byte_nxt   = cdtf_pkg::SEP_CLOSE;
          end_nxt    = 1'b1;
          ctrl.clear = 1'b1;
          phase_nxt  = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid     = valid_r;
  assign out_out_byte  = byte_r;
  assign out_frame_end = end_r;

endmodule
`default_nettype wire

>>> src/crc16_decimal_trailer_framer.sv
// Top level of the CRC-16 framer with decimal check trailer.
`default_nettype none
// Byte framer: every input word goes straight to the output and into a running
// CRC-16/XMODEM (poly 0x1021, init 0). A word flagged last_byte is followed by
// the trailer A1 F5 (folded into the CRC) A1 F6, two ASCII digits of CRC mod 99,
// A1 F6, with frame_end set on the closing F6; the CRC then returns to zero.
// Rate: one word per cycle for ordinary words while out_ready is high. A last
// word and the 8 trailer words leave through the single output register at that
// rate, and in_ready stays low while the trailer sequencer runs. The mod-99
// reduction (reciprocal multiply, then subtract) runs inside the trailer slots.
// in_ready also follows out_ready combinationally through the output register.
module crc16_decimal_trailer_framer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_out_byte,
  output logic            out_frame_end
);

  cdtf_pkg::crc_ctrl_t ctrl;
  logic [6:0]          rem;

  // sequencer owns the handshakes and the output register
  cdtf_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_frame_end (out_frame_end),
    .rem           (rem),
    .ctrl          (ctrl)
  );

  // CRC register plus mod-99 pipeline, stepped by the sequencer strobes
  cdtf_crc u_crc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .data_byte (in_data_byte),
    .rem_r     (rem)
  );

endmodule
`default_nettype wire

>>> src/cdtf_checker.sv
// Port-level checker for the framer, bound to the top level.
`default_nettype none
module cdtf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_data_byte,
  input wire logic       in_last_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_out_byte,
  input wire logic       out_frame_end
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_byte) && $stable(out_frame_end))
    else $error("output word changed while stalled");

  // accepted word shows up at the output next cycle
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && (out_out_byte == $past(in_data_byte)) && !out_frame_end)
    else $error("accepted word not passed through");

  // trailer blocks input
  a_trailer_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> !in_ready)
    else $error("input taken during trailer");

  // frame end only on closing separator, and input reopens when it is taken
  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> (out_out_byte == cdtf_pkg::SEP_CLOSE))
    else $error("frame end on wrong byte");

  a_end_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_end |-> in_ready)
    else $error("input not ready after frame end");

endmodule

bind crc16_decimal_trailer_framer cdtf_checker u_cdtf_checker (.*);
`default_nettype wire

>>> test/crc16_decimal_trailer_framer_test.sv
// Testbench for the CRC-16 decimal trailer framer: directed and random frames, scoreboarded.
`timescale 1ns / 100ps
module crc16_decimal_trailer_framer_test;

  // One output word as the framer should produce it.
  typedef struct packed {
    logic [7:0] value;
    logic       closing;
  } framed_word_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned DRAIN_WAIT  = 16;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_frame_end;

  // Predictor state: running CRC of the frame in progress.
  logic [15:0]  frame_crc = 16'h0000;
  framed_word_t expected_words[$];

  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;   // set: neither side idles

  crc16_decimal_trailer_framer DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_frame_end(out_frame_end)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bitwise CRC-16, poly 0x1021, MSB first, no reflection.
  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      top = r[15] ^ b[i];
      r   = {r[14:0], 1'b0};
      if (top) begin
        r = r ^ 16'h1021;
      end
    end
    return r;
  endfunction

  function automatic framed_word_t mk_word(input logic [7:0] v, input logic c);
    framed_word_t w;
    w.value   = v;
    w.closing = c;
    return w;
  endfunction

  // Queue up everything one accepted word should produce.
  task automatic frame_predict(input logic [7:0] b, input logic last);
    int unsigned check;
    expected_words.push_back(mk_word(b, 1'b0));
    frame_crc = crc_fold(frame_crc, b);
    if (last) begin
      // A1 F5 goes into the CRC; the rest of the trailer does not.
      frame_crc = crc_fold(frame_crc, cdtf_pkg::SEP_LEAD);
      frame_crc = crc_fold(frame_crc, cdtf_pkg::SEP_MID);
      check = int'(frame_crc) % 99;
      expected_words.push_back(mk_word(cdtf_pkg::SEP_LEAD, 1'b0));
      expected_words.push_back(mk_word(cdtf_pkg::SEP_MID, 1'b0));
      expected_words.push_back(mk_word(cdtf_pkg::SEP_LEAD, 1'b0));
      expected_words.push_back(mk_word(cdtf_pkg::SEP_CLOSE, 1'b0));
      expected_words.push_back(mk_word(cdtf_pkg::ASCII_ZERO + 8'(check / 10), 1'b0));
      expected_words.push_back(mk_word(cdtf_pkg::ASCII_ZERO + 8'(check % 10), 1'b0));
      expected_words.push_back(mk_word(cdtf_pkg::SEP_LEAD, 1'b0));
      expected_words.push_back(mk_word(cdtf_pkg::SEP_CLOSE, 1'b1));
      frame_crc = 16'h0000;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one word; valid stays up until the framer takes it.
  // Before that, idle cycles are drawn one at a time, each with an IDLE_PCT percent chance.
  task automatic send_word(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    frame_predict(b, last);
    words_sent++;
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Random message length: mostly short, now and then a long one.
  function automatic int unsigned pick_len();
    return ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
  endfunction

  // Extremes, separator bytes inside the message, single-word frames, and
  // a frame whose check value is below ten (leading '0' digit).
  task automatic test_directed();
    int pick;
    logic [15:0] c;
    pick = -1;
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'hA1, 1'b0);
    send_word(8'hF5, 1'b0);
    send_word(8'hF6, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'hF6, 1'b1);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h0F, 1'b0);
    send_word(8'hF0, 1'b1);
    for (int b = 0; b < 256 && pick < 0; b++) begin
      c = crc_fold(16'h0000, 8'(b));
      c = crc_fold(c, cdtf_pkg::SEP_LEAD);
      c = crc_fold(c, cdtf_pkg::SEP_MID);
      if (int'(c) % 99 < 10) begin
        pick = b;
      end
    end
    if (pick >= 0) begin
      send_word(8'(pick), 1'b1);
    end
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_random_frames(input int unsigned upto);
    while (words_sent < upto) begin
      send_frame(pick_len());
    end
  endtask

  // Back-to-back words with the sink always ready.
  task automatic test_steady_burst(input int unsigned upto);
    steady = 1'b1;
    while (words_sent < upto) begin
      send_frame(pick_len());
    end
    steady = 1'b0;
  endtask

  // Sink stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every taken output word with the oldest expectation.
  always @(posedge clk) begin
    framed_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", int'(out_out_byte), 0);
      end else begin
        want = expected_words.pop_front();
        if (out_out_byte !== want.value) begin
          report_mismatch("out_byte", int'(out_out_byte), int'(want.value));
        end
        if (out_frame_end !== want.closing) begin
          report_mismatch("frame_end", int'(out_frame_end), int'(want.closing));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_frames(250);
    test_steady_burst(370);
    test_random_frames(470);

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("words still expected", 0, expected_words.size());
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
